FILE: rtl/core/assert_macros.svh
// Assertion macros for the top level of the septet unpacker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/gsm7u_pkg.sv
// Shared types, constants and the default alphabet table of the septet unpacker.
package gsm7u_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int LIMIT_W     = 16;
    localparam int SEPT_W      = 7;
    localparam int CP_W        = 10;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam logic [2:0]      LEFT_FULL  = 3'd6;
    localparam logic [CP_W-1:0] ASCII_MAX  = 10'h07F;
    localparam logic [7:0]      UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]      UTF8_CONT  = 8'h80;

    // One queue entry: one or two septets decoded from one input item
    typedef struct packed {
        logic [SEPT_W-1:0] sept0;
        logic [SEPT_W-1:0] sept1;
        logic              two;
        logic              text_end;
    } t_entry;

    // Basic default alphabet: septet code to Unicode code point
    localparam logic [CP_W-1:0] ALPHABET [128] = '{
        10'h040, 10'h0A3, 10'h024, 10'h0A5, 10'h0E8, 10'h0E9, 10'h0F9, 10'h0EC,
        10'h0F2, 10'h0C7, 10'h00A, 10'h0D8, 10'h0F8, 10'h00D, 10'h0C5, 10'h0E5,
        10'h394, 10'h05F, 10'h3A6, 10'h393, 10'h39B, 10'h3A9, 10'h3A0, 10'h3A8,
        10'h3A3, 10'h398, 10'h39E, 10'h01B, 10'h0C6, 10'h0E6, 10'h0DF, 10'h0C9,
        10'h020, 10'h021, 10'h022, 10'h023, 10'h0A4, 10'h025, 10'h026, 10'h027,
        10'h028, 10'h029, 10'h02A, 10'h02B, 10'h02C, 10'h02D, 10'h02E, 10'h02F,
        10'h030, 10'h031, 10'h032, 10'h033, 10'h034, 10'h035, 10'h036, 10'h037,
        10'h038, 10'h039, 10'h03A, 10'h03B, 10'h03C, 10'h03D, 10'h03E, 10'h03F,
        10'h0A1, 10'h041, 10'h042, 10'h043, 10'h044, 10'h045, 10'h046, 10'h047,
        10'h048, 10'h049, 10'h04A, 10'h04B, 10'h04C, 10'h04D, 10'h04E, 10'h04F,
        10'h050, 10'h051, 10'h052, 10'h053, 10'h054, 10'h055, 10'h056, 10'h057,
        10'h058, 10'h059, 10'h05A, 10'h0C4, 10'h0D6, 10'h0D1, 10'h0DC, 10'h0A7,
        10'h0BF, 10'h061, 10'h062, 10'h063, 10'h064, 10'h065, 10'h066, 10'h067,
        10'h068, 10'h069, 10'h06A, 10'h06B, 10'h06C, 10'h06D, 10'h06E, 10'h06F,
        10'h070, 10'h071, 10'h072, 10'h073, 10'h074, 10'h075, 10'h076, 10'h077,
        10'h078, 10'h079, 10'h07A, 10'h0E4, 10'h0F6, 10'h0F1, 10'h0FC, 10'h0E0
    };

endpackage

FILE: rtl/core/gsm7u_front.sv
// Front end: takes packed bytes, cuts septets and applies the septet limit.
module gsm7u_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_packed_byte,
    input  logic                          i_final_byte,
    input  logic [gsm7u_pkg::LIMIT_W-1:0] i_limit,
    input  logic                          i_full,
    output logic                          o_push,
    output gsm7u_pkg::t_entry             o_entry
);
    import gsm7u_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [5:0]             r_left;
    logic [5:0]             n_left;
    logic [2:0]             r_left_cnt;
    logic [2:0]             n_left_cnt;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;

    logic [13:0]            acc;
    logic                   wide;
    logic                   lim_on;
    logic                   want1;
    logic                   accept;
    logic [COUNT_WIDTH-1:0] cnt1;
    logic [COUNT_WIDTH-1:0] cnt2;
    logic                   reach0;
    logic                   reach1;
    logic                   reach2;
    logic                   put0;
    logic                   put1;
    logic                   ended;

    // Append the new byte above the leftover bits
    assign acc    = {8'b0, r_left} | ({6'b0, i_packed_byte} << r_left_cnt);
    assign wide   = (r_left_cnt == LEFT_FULL);
    assign lim_on = (i_limit != '0);
    assign want1  = wide || (i_final_byte && lim_on);
    assign accept = i_in_valid && !i_full;

    // Walk the limit through the first and the second septet
    assign reach0 = lim_on && (CMP_W'(r_count) >= CMP_W'(i_limit));
    assign put0   = !reach0;
    assign cnt1   = (r_count == COUNT_MAX) ? r_count : r_count + COUNT_WIDTH'(1);
    assign reach1 = lim_on && (CMP_W'(cnt1) >= CMP_W'(i_limit));
    assign put1   = put0 && want1 && !reach1;
    assign cnt2   = (cnt1 == COUNT_MAX) ? cnt1 : cnt1 + COUNT_WIDTH'(1);
    assign reach2 = lim_on && (CMP_W'(cnt2) >= CMP_W'(i_limit));
    assign ended  = (put0 && reach1) || (put1 && reach2) || i_final_byte;

    // Next leftover and septet count
    always_comb begin
        n_left     = r_left;
        n_left_cnt = r_left_cnt;
        n_count    = r_count;
        if (accept) begin
            if (i_final_byte) begin
                n_left     = '0;
                n_left_cnt = '0;
                n_count    = '0;
            end else begin
                if (wide) begin
                    n_left     = '0;
                    n_left_cnt = '0;
                end else begin
                    n_left     = acc[12:7];
                    n_left_cnt = r_left_cnt + 3'd1;
                end
                if (put1) begin
                    n_count = cnt2;
                end else if (put0) begin
                    n_count = cnt1;
                end
            end
        end
    end

    // Hold the unpacking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left     <= '0;
            r_left_cnt <= '0;
            r_count    <= '0;
        end else begin
            r_left     <= n_left;
            r_left_cnt <= n_left_cnt;
            r_count    <= n_count;
        end
    end

    // Queue an item only when it yields at least one septet
    assign o_in_stall       = i_full;
    assign o_push           = accept && put0;
    assign o_entry.sept0    = acc[6:0];
    assign o_entry.sept1    = acc[13:7];
    assign o_entry.two      = put1;
    assign o_entry.text_end = ended;

endmodule

FILE: rtl/core/gsm7u_fifo.sv
// Short queue of septet entries between the front and back ends.
module gsm7u_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gsm7u_pkg::t_entry i_entry,
    output logic              o_full,
    input  logic              i_pop,
    output gsm7u_pkg::t_entry o_head,
    output logic              o_empty
);
    import gsm7u_pkg::*;

    t_entry             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_AW:0]   r_cnt;

    // Write the entry at the tail
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (FIFO_AW + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (FIFO_AW + 1)'(1);
            end
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_full  = (r_cnt == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

FILE: rtl/core/gsm7u_back.sv
// Back end: maps septets through the alphabet and sends UTF-8 bytes one a cycle while not stalled.
module gsm7u_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  gsm7u_pkg::t_entry i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_utf8_byte,
    output logic              o_run_last,
    output logic              o_text_end
);
    import gsm7u_pkg::*;

    typedef enum logic [1:0] {
        PH_S0_LEAD,
        PH_S0_CONT,
        PH_S1_LEAD,
        PH_S1_CONT
    } t_phase;

    t_phase            r_phase;
    t_phase            n_phase;
    logic              r_valid;
    logic [7:0]        r_byte;
    logic              r_run_last;
    logic              r_text_end;

    logic              sel1;
    logic              cont;
    logic [SEPT_W-1:0] sept;
    logic [CP_W-1:0]   cp;
    logic              multi;
    logic [7:0]        byte_val;
    logic              sept_done;
    logic              entry_done;
    logic              load;

    // Decode the phase into septet select and continuation byte
    always_comb begin
        sel1 = 1'b0;
        cont = 1'b0;
        case (r_phase)
            PH_S0_LEAD: begin
                sel1 = 1'b0;
                cont = 1'b0;
            end
            PH_S0_CONT: begin
                sel1 = 1'b0;
                cont = 1'b1;
            end
            PH_S1_LEAD: begin
                sel1 = 1'b1;
                cont = 1'b0;
            end
            PH_S1_CONT: begin
                sel1 = 1'b1;
                cont = 1'b1;
            end
            default: begin
                sel1 = 1'b0;
                cont = 1'b0;
            end
        endcase
    end

    // Look up the code point and form the current byte
    assign sept       = sel1 ? i_head.sept1 : i_head.sept0;
    assign cp         = ALPHABET[sept];
    assign multi      = (cp > ASCII_MAX);
    assign byte_val   = cont  ? (UTF8_CONT | {2'b0, cp[5:0]}) :
                        multi ? (UTF8_LEAD2 | {4'b0, cp[9:6]}) : cp[7:0];
    assign sept_done  = cont || !multi;
    assign entry_done = sept_done && (sel1 || !i_head.two);
    assign load       = !i_empty && (!r_valid || !i_out_stall);
    assign o_pop      = load && entry_done;

    // Pick the next phase
    always_comb begin
        n_phase = r_phase;
        if (entry_done) begin
            n_phase = PH_S0_LEAD;
        end else if (sept_done) begin
            n_phase = PH_S1_LEAD;
        end else if (sel1) begin
            n_phase = PH_S1_CONT;
        end else begin
            n_phase = PH_S0_CONT;
        end
    end

    // Hold the phase and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_S0_LEAD;
            r_valid <= 1'b0;
        end else if (load) begin
            r_phase    <= n_phase;
            r_valid    <= 1'b1;
            r_byte     <= byte_val;
            r_run_last <= entry_done;
            r_text_end <= entry_done && i_head.text_end;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_valid;
    assign o_utf8_byte = r_byte;
    assign o_run_last  = r_run_last;
    assign o_text_end  = r_text_end;

endmodule

FILE: rtl/core/gsm7_septet_unpack_to_utf8.sv
// Top level: GSM 7-bit packed bytes in, UTF-8 bytes of the decoded text out.
//
//  channel   valid / stall              payload
//  in        i_in_valid / o_in_stall    i_packed_byte, i_final_byte
//  out       o_out_valid / i_out_stall  o_utf8_byte, o_run_last, o_text_end
//  config    i_cfg_we                   i_cfg_wdata (septet limit)
//
// The front end takes one byte a cycle while the entry queue has room.
// The back end sends one UTF-8 byte a cycle while the output is not stalled;
// an item gives 0-4 bytes: none past the limit, else 1-2 septets of 1-2 bytes.
// Synchronous active-low reset clears the leftover bits, the septet count,
// the queue and the output register; the septet limit resets to zero.
// A stall on the output holds the output register and fills the queue.
`include "assert_macros.svh"

module gsm7_septet_unpack_to_utf8 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_packed_byte,
    input  logic                          i_final_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_utf8_byte,
    output logic                          o_run_last,
    output logic                          o_text_end,
    input  logic                          i_cfg_we,
    input  logic [gsm7u_pkg::LIMIT_W-1:0] i_cfg_wdata
);
    import gsm7u_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    logic               w_full;
    logic               w_push;
    logic               w_pop;
    logic               w_empty;
    t_entry             w_entry;
    t_entry             w_head;

    // Hold the septet limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    gsm7u_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_packed_byte (i_packed_byte),
        .i_final_byte  (i_final_byte),
        .i_limit       (r_limit),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_entry       (w_entry)
    );

    gsm7u_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty)
    );

    gsm7u_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_utf8_byte (o_utf8_byte),
        .o_run_last  (o_run_last),
        .o_text_end  (o_text_end)
    );

    `ASSERT_RST(a_no_push_full, i_clk, i_rst_n, w_full |-> !w_push, "push into full queue")
    `ASSERT_RST(a_no_pop_empty, i_clk, i_rst_n, w_pop |-> !w_empty, "pop from empty queue")
    `ASSERT_RST(a_end_is_last, i_clk, i_rst_n, (o_out_valid && o_text_end) |-> o_run_last, "text end not on last byte of item")

endmodule
